@@ src/bia_pkg.sv @@
// Shared types, codes and helpers for the bitmap id allocator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

	localparam int ID_COUNT_DEF = 1024;
	localparam int KIND_W       = 2;
	localparam int ID_W         = 10;
	localparam int STATUS_W     = 2;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // write one zero word of the clearing pass
		logic accept;  // latch the item, issue the word read
		logic scan;    // examine one group of the word-full summary
		logic finish;  // modify/write the word, load the result register
	} bia_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic need_scan;
		logic scan_hit;
		logic scan_end;
	} bia_stat_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} bia_zero_t;

	// lowest zero bit of a word
	function automatic bia_zero_t first_zero(input logic [WORD_W-1:0] w);
		bia_zero_t r;
		r.found = 1'b0;
		r.pos   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r.found = 1'b1;
				r.pos   = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/bia_if.sv @@
// Request and response channel interfaces of the bitmap id allocator.
// Depends on bia_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bia_req_if;
	logic                        valid;
	logic                        ready;
	logic [bia_pkg::KIND_W-1:0]  kind;
	logic [bia_pkg::ID_W-1:0]    id;

	modport source (output valid, kind, id, input ready);
	modport sink   (input valid, kind, id, output ready);
endinterface

interface bia_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bia_pkg::ID_W-1:0]     given_id;
	logic [bia_pkg::STATUS_W-1:0] status;

	modport source (output valid, given_id, status, input ready);
	modport sink   (input valid, given_id, status, output ready);
endinterface

`default_nettype wire

@@ src/bia_ctrl.sv @@
// Sequencer of the bitmap id allocator: clearing pass, accept, scan, finish.
// Depends on bia_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bia_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bia_pkg::bia_cmd_t       cmd,
	input  wire bia_pkg::bia_stat_t st
);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = st.need_scan ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_hit || st.scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bia_dp.sv @@
// Datapath of the bitmap id allocator: bitmap memory, word-full summary,
// remembered id, scan group counter and result register. Depends on bia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bia_dp #(
	parameter int ID_COUNT = bia_pkg::ID_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bia_pkg::bia_cmd_t             cmd,
	output bia_pkg::bia_stat_t                 st,
	input  wire logic [bia_pkg::KIND_W-1:0]    in_kind,
	input  wire logic [bia_pkg::ID_W-1:0]      in_id,
	output logic [bia_pkg::ID_W-1:0]           given_id,
	output logic [bia_pkg::STATUS_W-1:0]       status
);

	localparam int WORD_COUNT  = (ID_COUNT + 31) / 32;
	localparam int WA          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int CHUNK_COUNT = (WORD_COUNT + 31) / 32;
	localparam int CA          = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
	localparam int PAD_W       = CHUNK_COUNT * 32;
	localparam int WW          = bia_pkg::WORD_W;
	localparam int BW          = bia_pkg::BIT_W;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_RELEASE,
		OP_RESERVE,
		OP_NONE
	} op_t;

	function automatic logic [WA-1:0] word_of(input logic [bia_pkg::ID_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[WA+4:5];
	endfunction

	// bitmap memory
	logic [WW-1:0] mem_q [WORD_COUNT];
	logic [WW-1:0] rdata_q;
	logic          rd_en, wr_en;
	logic [WA-1:0] rd_addr, wr_addr;
	logic [WW-1:0] wr_data;

	// state
	logic [WORD_COUNT-1:0]         full_q;
	logic                          recent_valid_q;
	logic [bia_pkg::ID_W-1:0]      recent_id_q;
	logic [WA-1:0]                 clr_q;
	logic [CA-1:0]                 chunk_q;
	op_t                           op_q;
	logic                          from_scan_q;
	logic [WA-1:0]                 addr_q;
	logic [BW-1:0]                 bit_q;
	logic [bia_pkg::ID_W-1:0]      id_q;
	logic [bia_pkg::STATUS_W-1:0]  rstat_q;
	logic [bia_pkg::ID_W-1:0]      given_q;
	logic [bia_pkg::STATUS_W-1:0]  status_q;

	// accept decode
	logic          in_range;
	logic [WA-1:0] acc_addr;
	assign in_range = 32'(in_id) < 32'(ID_COUNT);
	always_comb begin
		if (in_kind == bia_pkg::KIND_ALLOC) begin
			acc_addr = word_of(recent_id_q);
		end else begin
			acc_addr = word_of(in_id);
		end
	end

	// summary scan, one group of 32 words per step
	logic [PAD_W-1:0]   padded;
	logic [31:0]        group;
	bia_pkg::bia_zero_t gz;
	logic [31:0]        sw32;
	logic [WA-1:0]      scan_addr;
	always_comb begin
		padded                   = '1;
		padded[WORD_COUNT-1:0]   = full_q;
	end
	assign group     = padded[chunk_q*32 +: 32];
	assign gz        = bia_pkg::first_zero(group);
	assign sw32      = (32'(chunk_q) << 5) | 32'(gz.pos);
	assign scan_addr = sw32[WA-1:0];

	assign st.clear_last = (clr_q == WA'(WORD_COUNT - 1));
	assign st.need_scan  = (in_kind == bia_pkg::KIND_ALLOC) && !recent_valid_q;
	assign st.scan_hit   = gz.found;
	assign st.scan_end   = (chunk_q == CA'(CHUNK_COUNT - 1));

	// finish: modify the word read at accept or scan
	bia_pkg::bia_zero_t wz;
	logic [31:0]        cand32;
	logic               cand_ok;
	logic [BW-1:0]      wbit;
	logic [WW-1:0]      mask;
	logic [WW-1:0]      new_word;
	logic               fin_write;
	logic [bia_pkg::ID_W-1:0]     fin_given;
	logic [bia_pkg::STATUS_W-1:0] fin_status;

	assign wz      = bia_pkg::first_zero(rdata_q);
	assign cand32  = (32'(addr_q) << 5) | 32'(wz.pos);
	assign cand_ok = cand32 < 32'(ID_COUNT);
	assign wbit    = from_scan_q ? wz.pos : bit_q;
	assign mask    = WW'(1) << wbit;

	always_comb begin
		new_word   = rdata_q | mask;
		fin_write  = 1'b0;
		fin_given  = '0;
		fin_status = rstat_q;
		unique case (op_q)
			OP_ALLOC: begin
				if (from_scan_q) begin
					if (cand_ok) begin
						fin_write = 1'b1;
						fin_given = cand32[bia_pkg::ID_W-1:0];
					end else begin
						fin_status = bia_pkg::ST_FULL;
					end
				end else begin
					fin_write = 1'b1;
					fin_given = recent_id_q;
				end
			end
			OP_RELEASE: begin
				new_word  = rdata_q & ~mask;
				fin_write = 1'b1;
			end
			OP_RESERVE: begin
				fin_write = 1'b1;
			end
			OP_NONE: begin
				fin_write = 1'b0;
			end
			default: begin
				fin_write = 1'b0;
			end
		endcase
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = acc_addr;
		if (cmd.accept) begin
			rd_en = 1'b1;
		end else if (cmd.scan && gz.found) begin
			rd_en   = 1'b1;
			rd_addr = scan_addr;
		end
	end

	assign wr_en   = cmd.clear || (cmd.finish && fin_write);
	assign wr_addr = cmd.clear ? clr_q : addr_q;
	assign wr_data = cmd.clear ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q         <= '0;
			recent_valid_q <= 1'b0;
			recent_id_q    <= '0;
			clr_q          <= '0;
			chunk_q        <= '0;
			op_q           <= OP_NONE;
			from_scan_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + WA'(1);
			end
			if (cmd.accept) begin
				chunk_q     <= '0;
				from_scan_q <= st.need_scan;
				priority if (in_kind == bia_pkg::KIND_ALLOC) begin
					op_q <= OP_ALLOC;
				end else if (in_kind == bia_pkg::KIND_RELEASE && in_range) begin
					op_q <= OP_RELEASE;
				end else if (in_kind == bia_pkg::KIND_RESERVE && in_range) begin
					op_q <= OP_RESERVE;
				end else begin
					op_q <= OP_NONE;
				end
			end
			if (cmd.scan) begin
				if (!gz.found) begin
					chunk_q <= chunk_q + CA'(1);
					if (st.scan_end) begin
						op_q <= OP_NONE;
					end
				end
			end
			if (cmd.finish) begin
				if (fin_write) begin
					full_q[addr_q] <= (new_word == '1);
				end
				if (op_q == OP_ALLOC && !from_scan_q) begin
					recent_valid_q <= 1'b0;
				end
				if (op_q == OP_RELEASE) begin
					recent_valid_q <= 1'b1;
					recent_id_q    <= id_q;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q    <= in_id;
			addr_q  <= acc_addr;
			bit_q   <= (in_kind == bia_pkg::KIND_ALLOC) ? recent_id_q[BW-1:0] : in_id[BW-1:0];
			priority if (in_kind == bia_pkg::KIND_RELEASE && !in_range) begin
				rstat_q <= bia_pkg::ST_RANGE;
			end else if (in_kind == bia_pkg::KIND_RESERVE && !in_range) begin
				rstat_q <= bia_pkg::ST_RANGE;
			end else begin
				rstat_q <= bia_pkg::ST_OK;
			end
		end
		if (cmd.scan) begin
			if (gz.found) begin
				addr_q <= scan_addr;
			end else if (st.scan_end) begin
				rstat_q <= bia_pkg::ST_FULL;
			end
		end
		if (cmd.finish) begin
			given_q  <= fin_given;
			status_q <= fin_status;
		end
	end

	assign given_id = given_q;
	assign status   = status_q;

endmodule

`default_nettype wire

@@ src/bitmap_id_allocator_unit.sv @@
// Top level of the bitmap id allocator: joins the sequencer and the datapath.
// Depends on bia_pkg, bia_if (bia_req_if, bia_rsp_if), bia_ctrl and bia_dp.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload              | Accepted when
// req     | in  | kind[1:0], id[9:0]   | req.valid && req.ready
// rsp     | out | given_id[9:0], status| rsp.valid && rsp.ready
//
// Steps: release, reserve, kind 3, allocate of the remembered id and every out of
//   range request go through accept with word read, then modify/write.
//   Allocate from the bitmap adds one scan step per 32-word group of the
//   word-full summary scanned, 1 to ceil(WORD_COUNT/32) groups.
//   The bitmap memory and its registered read set these steps.
// Reset: after arst_n releases, a clearing pass writes WORD_COUNT zero words
//   with req.ready low.
// Stalls: a result waits in the output register; the next item is accepted
//   meanwhile and holds in its finish step until the register is free.

module bitmap_id_allocator_unit #(
	parameter int ID_COUNT = bia_pkg::ID_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bia_req_if.sink    req,
	bia_rsp_if.source  rsp
);

	bia_pkg::bia_cmd_t  cmd;
	bia_pkg::bia_stat_t st;

	// sequencer: one item at a time
	bia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	// bitmap, summary, remembered id, result register
	bia_dp #(
		.ID_COUNT (ID_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_kind  (req.kind),
		.in_id    (req.id),
		.given_id (rsp.given_id),
		.status   (rsp.status)
	);

endmodule

`default_nettype wire

@@ bench/bitmap_id_allocator_unit_test.sv @@
// Self-checking bench for bitmap_id_allocator_unit: allocate, release and reserve traffic
// checked item by item against a behavioral model of the id pool kept in the bench.
// Depends on bia_pkg, bia_if and the RTL under src.
`timescale 1ns / 1ps

module bitmap_id_allocator_unit_test;

	localparam int ID_COUNT   = bia_pkg::ID_COUNT_DEF;
	localparam int WORD_COUNT = (ID_COUNT + 31) / 32;
	localparam int ID_W       = bia_pkg::ID_W;
	localparam int KIND_W     = bia_pkg::KIND_W;
	localparam int WORD_W     = bia_pkg::WORD_W;
	localparam int BIT_W      = bia_pkg::BIT_W;

	// kind 3 has no name in the package; the block treats it as a no-op
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// cycles of the long output hold-off, and the drain margin at the end
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_NS     = 2_000_000;

	typedef struct packed {
		logic [bia_pkg::ID_W-1:0]     given_id;
		logic [bia_pkg::STATUS_W-1:0] status;
	} grant_t;

	logic clk;
	logic arst_n;

	bia_req_if req_ch ();
	bia_rsp_if rsp_ch ();

	bitmap_id_allocator_unit #(
		.ID_COUNT(ID_COUNT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Pool model: one used mark per id plus the most recently released id.
	logic [WORD_W-1:0] used_map [WORD_COUNT];
	logic [ID_W-1:0]   last_freed_id;
	logic              last_freed_valid;

	grant_t grant_q [$];   // expected results, oldest first
	int     fail_count;

	// sender idling
	logic steady_send;     // no gaps while set
	int   burst_left;

	// receiver long hold-off requests, served in the receiver process
	int hold_asked;
	int hold_served;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one operation to the pool model and returns the result it gives.
	function automatic grant_t apply_op(input logic [KIND_W-1:0] k,
			input logic [ID_W-1:0] v);
		grant_t g;
		logic   hit;
		int     pick;
		g.given_id = '0;
		g.status   = bia_pkg::ST_OK;
		case (k)
			bia_pkg::KIND_ALLOC: begin
				if (last_freed_valid) begin
					// remembered id wins, even if reserved since its release
					last_freed_valid = 1'b0;
					used_map[last_freed_id[ID_W-1:BIT_W]][last_freed_id[BIT_W-1:0]] = 1'b1;
					g.given_id = last_freed_id;
				end else begin
					hit  = 1'b0;
					pick = 0;
					for (int w = 0; w < WORD_COUNT; w++) begin
						for (int b = 0; b < WORD_W; b++) begin
							if (!hit && !used_map[w][b]) begin
								hit  = 1'b1;
								pick = w * WORD_W + b;
							end
						end
					end
					if (hit && pick < ID_COUNT) begin
						used_map[pick / WORD_W][pick % WORD_W] = 1'b1;
						g.given_id = ID_W'(pick);
					end else begin
						g.status = bia_pkg::ST_FULL;
					end
				end
			end
			bia_pkg::KIND_RELEASE: begin
				if (int'(v) < ID_COUNT) begin
					last_freed_id    = v;
					last_freed_valid = 1'b1;
					used_map[v[ID_W-1:BIT_W]][v[BIT_W-1:0]] = 1'b0;
				end else begin
					g.status = bia_pkg::ST_RANGE;
				end
			end
			bia_pkg::KIND_RESERVE: begin
				// leaves the remembered id alone
				if (int'(v) < ID_COUNT)
					used_map[v[ID_W-1:BIT_W]][v[BIT_W-1:0]] = 1'b1;
				else
					g.status = bia_pkg::ST_RANGE;
			end
			default: begin
			end
		endcase
		return g;
	endfunction

	// Offers one item, waits for the handshake, records the expected result,
	// then maybe drops valid for a random gap at the end of a burst.
	task automatic issue_op(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] v);
		req_ch.valid <= 1'b1;
		req_ch.kind  <= k;
		req_ch.id    <= v;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		grant_q.push_back(apply_op(k, v));
		if (!steady_send) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				req_ch.valid <= 1'b0;
				req_ch.kind  <= KIND_W'($urandom);
				req_ch.id    <= ID_W'($urandom);
				repeat ($urandom_range(1, 6))
					@(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Sender pause: nothing offered until every expected result is in.
	task automatic wait_drained;
		req_ch.valid <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Field extremes, each kind, the remembered-id rules and the no-op kind.
	task automatic test_directed;
		issue_op(bia_pkg::KIND_ALLOC, 10'h3ff);     // empty pool -> 0
		issue_op(bia_pkg::KIND_ALLOC, 10'h000);     // -> 1
		issue_op(bia_pkg::KIND_RELEASE, 10'd0);     // remember 0
		issue_op(bia_pkg::KIND_RESERVE, 10'd0);     // reserve the remembered id
		issue_op(bia_pkg::KIND_ALLOC, 10'h155);     // still hands out 0
		issue_op(bia_pkg::KIND_ALLOC, 10'h2aa);     // memory cleared: scan -> 2
		issue_op(bia_pkg::KIND_RELEASE, 10'd1023);  // top id, never used
		issue_op(bia_pkg::KIND_RESERVE, 10'd1023);
		issue_op(KIND_UNUSED, 10'd1023);            // no-op kind, all id bits high
		issue_op(KIND_UNUSED, 10'd0);
		issue_op(bia_pkg::KIND_RELEASE, 10'd5);
		issue_op(bia_pkg::KIND_RELEASE, 10'd7);     // only the latest release is kept
		issue_op(bia_pkg::KIND_ALLOC, 10'd0);       // -> 7
		issue_op(bia_pkg::KIND_ALLOC, 10'd0);       // scan -> 3
		issue_op(bia_pkg::KIND_RESERVE, 10'd31);    // word boundary
		issue_op(bia_pkg::KIND_RESERVE, 10'd32);
		issue_op(bia_pkg::KIND_RELEASE, 10'd512);
		issue_op(bia_pkg::KIND_ALLOC, 10'd0);       // -> 512
		issue_op(bia_pkg::KIND_ALLOC, 10'd0);
		issue_op(bia_pkg::KIND_RELEASE, 10'd1);
		issue_op(bia_pkg::KIND_RESERVE, 10'd1);
		issue_op(bia_pkg::KIND_ALLOC, 10'd0);       // -> 1 again
		wait_drained();
	endtask

	// Receiver holds off long while the sender keeps offering back to back,
	// so the block fills up and stalls its request side.
	task automatic test_stalled_output;
		steady_send = 1'b1;
		hold_asked++;
		for (int n = 0; n < 24; n++) begin
			if (n % 3 == 0)
				issue_op(bia_pkg::KIND_RELEASE, ID_W'($urandom_range(0, 63)));
			else
				issue_op(bia_pkg::KIND_ALLOC, ID_W'($urandom));
		end
		steady_send = 1'b0;
		wait_drained();
	endtask

	// Random traffic; about one chunk in three runs with no sender gaps.
	task automatic test_random_mix(input int count, input int alloc_pct,
			input int release_pct, input int wide_pct);
		int                r;
		logic [KIND_W-1:0] k;
		logic [ID_W-1:0]   v;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				steady_send = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < alloc_pct)
				k = bia_pkg::KIND_ALLOC;
			else if (r < alloc_pct + release_pct)
				k = bia_pkg::KIND_RELEASE;
			else if (r < 96)
				k = bia_pkg::KIND_RESERVE;
			else
				k = KIND_UNUSED;
			// low ids are where allocations land, so targets not drawn wide go there
			if ($urandom_range(0, 99) < wide_pct)
				v = ID_W'($urandom);
			else
				v = ID_W'($urandom_range(0, 159));
			issue_op(k, v);
		end
		steady_send = 1'b0;
	endtask

	// Receiver: switches between always ready, a fixed stall pattern and
	// random stalls; a hold-off request overrides all of them.
	initial begin
		int mode;
		int span;
		int phase;
		int hold_left;
		mode      = 0;
		span      = 0;
		phase     = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 2);
					span = $urandom_range(16, 96);
				end
				span--;
				phase++;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= (phase % 7) >= 3;
					default: rsp_ch.ready <= ($urandom_range(0, 9) >= 4);
				endcase
			end
		end
	end

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		grant_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result given_id %0d status %0d", $time,
					rsp_ch.given_id, rsp_ch.status);
				fail_count++;
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.given_id !== want.given_id) begin
					$display("%0t: given_id mismatch: expected %0d actual %0d", $time,
						want.given_id, rsp_ch.given_id);
					fail_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d", $time,
						want.status, rsp_ch.status);
					fail_count++;
				end
			end
		end
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		fail_count       = 0;
		steady_send      = 1'b0;
		burst_left       = 0;
		hold_asked       = 0;
		hold_served      = 0;
		last_freed_id    = '0;
		last_freed_valid = 1'b0;
		for (int w = 0; w < WORD_COUNT; w++)
			used_map[w] = '0;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= bia_pkg::KIND_ALLOC;
		req_ch.id    <= '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset keeps req.ready low; issue_op waits it out

		test_directed();
		test_stalled_output();
		test_random_mix(300, 45, 25, 30);
		// releases and reserves spread over every word
		test_random_mix(300, 40, 35, 90);

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (grant_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, grant_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/bia_pkg.sv
src/bia_if.sv
src/bia_ctrl.sv
src/bia_dp.sv
src/bitmap_id_allocator_unit.sv
bench/bitmap_id_allocator_unit_test.sv
